>>> rtl/wakr_pkg.sv
// Shared types and constants for the sunrise alarm lamp ramp.
// No dependencies; every other file in rtl/ imports this package.
package wakr_pkg;

  // Register file geometry and reset contents.
  localparam int unsigned EntrySlots   = 8;
  localparam int unsigned EntryIdxW    = 3;
  localparam int unsigned ApbAw        = 5;
  localparam int unsigned ApbDw        = 32;
  localparam logic [31:0] Entry0Reset  = 32'h0900_0F19;

  // Defaults for the top-level parameters.
  localparam int unsigned NumAlarmsDef = 8;
  localparam int unsigned TicksPerMinDef = 120;

  // Ramp arithmetic.
  localparam logic [7:0]  LevelCap     = 8'd254;
  localparam logic [15:0] CountLimitMax = 16'hFFFE;
  localparam int unsigned NumW         = 24;
  localparam int unsigned DenW         = 16;
  localparam int unsigned DivSteps     = NumW;
  localparam int unsigned DivCntW      = $clog2(DivSteps);

  // Input beat.
  typedef struct packed {
    logic       mode;
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic       override;
  } wakr_in_t;

  // Result beat.
  typedef struct packed {
    logic       led_write;
    logic [7:0] level;
    logic       running;
    logic [2:0] alarm_index;
  } wakr_out_t;

  // One alarm entry as stored in a register.
  typedef struct packed {
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] fade;
    logic [7:0] hold;
  } wakr_entry_t;

  // Divider status back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } wakr_div_sts_t;

  // Input modes.
  localparam logic ModeTime = 1'b0;
  localparam logic ModeTick = 1'b1;

endpackage

>>> rtl/wakr_regs.sv
// Alarm entry registers behind an APB-style port, plus the sequencer read port.
// Depends on wakr_pkg.
module wakr_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [wakr_pkg::ApbAw-1:0]            paddr,
  input  logic [wakr_pkg::ApbDw-1:0]            pwdata,
  output logic [wakr_pkg::ApbDw-1:0]            prdata,
  output logic                                  pready,
  input  logic [wakr_pkg::EntryIdxW-1:0]        rd_idx_i,
  output wakr_pkg::wakr_entry_t                 rd_entry_o
);
  import wakr_pkg::*;

  logic [ApbDw-1:0]     entries_q [EntrySlots];
  logic [EntryIdxW-1:0] wr_idx;
  logic                 wr_en;

  // Word address selects the entry; the low two bits are byte offsets.
  assign wr_idx = paddr[ApbAw-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < EntrySlots; i++) begin
        entries_q[i] <= (i == 0) ? Entry0Reset : '0;
      end
    end else if (wr_en) begin
      entries_q[wr_idx] <= pwdata;
    end
  end

  // Bus read and sequencer read.
  assign prdata     = entries_q[wr_idx];
  assign rd_entry_o = wakr_entry_t'(entries_q[rd_idx_i]);

endmodule

>>> rtl/wakr_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on wakr_pkg.
module wakr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [wakr_pkg::NumW-1:0]   num_i,
  input  logic [wakr_pkg::DenW-1:0]   den_i,
  output wakr_pkg::wakr_div_sts_t     sts_o,
  output logic [wakr_pkg::NumW-1:0]   quot_o
);
  import wakr_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DenW-1:0]    rem_q, rem_d;
  logic [DenW-1:0]    den_q, den_d;
  logic [NumW-1:0]    quo_q, quo_d;
  logic [DenW:0]      trial;
  logic               ge;

  // Shift the next numerator bit into the partial remainder and compare.
  assign trial = {rem_q, quo_q[NumW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      den_d  = den_i;
      quo_d  = num_i;
    end else if (busy_q) begin
      rem_d = ge ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
      quo_d = {quo_q[NumW-2:0], ge};
      cnt_d = DivCntW'(cnt_q + 1'b1);
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quot_o     = quo_q;

endmodule

>>> rtl/wakeup_alarm_light_ramp.sv
// Top level of the sunrise alarm lamp ramp: sequencer, state and output register.
// Depends on wakr_pkg, wakr_regs and wakr_div.
//
// One beat is in work at a time; in_stall_o is low only while the sequencer
// is idle, and a finished result waits in the output register so the next
// beat can be taken while it is still stalled. A time beat that cannot start
// a run goes straight to the result; otherwise the scan walks the entries in
// order up to NUM_ALARMS and stops at the first match. A tick beat outside a
// run goes straight to the result; a tick in a run passes prepare and check,
// where a tick that ends the run or saturates the level stops; a rising ramp
// tick uses the 24-step divider: floor(255 * count / (fade * TICKS_PER_MINUTE)).
module wakeup_alarm_light_ramp #(
  parameter int unsigned NUM_ALARMS       = wakr_pkg::NumAlarmsDef,
  parameter int unsigned TICKS_PER_MINUTE = wakr_pkg::TicksPerMinDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  wakr_pkg::wakr_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output wakr_pkg::wakr_out_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wakr_pkg::ApbAw-1:0]    paddr,
  input  logic [wakr_pkg::ApbDw-1:0]    pwdata,
  output logic [wakr_pkg::ApbDw-1:0]    prdata,
  output logic                          pready
);
  import wakr_pkg::*;

  localparam logic [7:0]           TpmW     = 8'(TICKS_PER_MINUTE);
  localparam logic [EntryIdxW-1:0] LastIdx  = EntryIdxW'(NUM_ALARMS - 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_PREP  = 6'b000100,
    ST_CHECK = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_DONE  = 6'b100000
  } wakr_state_e;

  wakr_state_e          state_q, state_d;
  wakr_in_t             item_q, item_d;
  logic [EntryIdxW-1:0] idx_q, idx_d;
  logic                 run_q, run_d;
  logic [EntryIdxW-1:0] active_q, active_d;
  logic [15:0]          count_q, count_d;
  logic [DenW-1:0]      den_q, den_d;
  logic [15:0]          limit_q, limit_d;
  logic                 disabled_q, disabled_d;
  logic                 led_q, led_d;
  logic [7:0]           level_q, level_d;
  logic                 out_valid_q, out_valid_d;
  wakr_out_t            out_q, out_d;

  logic [EntryIdxW-1:0] rd_idx;
  wakr_entry_t          entry;
  logic                 entry_on;
  logic                 entry_hit;
  logic [16:0]          limit_full;
  logic                 div_start;
  logic [NumW-1:0]      div_num;
  logic [NumW-1:0]      div_quot;
  wakr_div_sts_t        div_sts;

  // Alarm table.
  wakr_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .rd_idx_i   (rd_idx),
    .rd_entry_o (entry)
  );

  // Serial divider.
  wakr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .sts_o   (div_sts),
    .quot_o  (div_quot)
  );

  // The scan walks the table; everything else reads the running entry.
  assign rd_idx    = (state_q == ST_SCAN) ? idx_q : active_q;
  assign entry_on  = (entry.hour != 8'd0) || (entry.minute != 8'd0);
  assign entry_hit = entry_on && (entry.hour == {3'b000, item_q.hour})
                     && (entry.minute == {2'b00, item_q.minute});
  assign limit_full = 17'(({1'b0, entry.fade} + {1'b0, entry.hold}) * TpmW);

  // 255 * count as a shift and subtract.
  assign div_num = {count_q, 8'h00} - NumW'(count_q);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    idx_d       = idx_q;
    run_d       = run_q;
    active_d    = active_q;
    count_d     = count_q;
    den_d       = den_q;
    limit_d     = limit_q;
    disabled_d  = disabled_q;
    led_d       = led_q;
    level_d     = level_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_start   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          idx_d   = '0;
          led_d   = 1'b0;
          level_d = 8'd0;
          if (in_data_i.mode == ModeTime) begin
            if (!in_data_i.override && !run_q && (in_data_i.weekday >= 3'd1)
                && (in_data_i.weekday <= 3'd5)) begin
              state_d = ST_SCAN;
            end else begin
              state_d = ST_DONE;
            end
          end else if (run_q) begin
            state_d = ST_PREP;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (entry_hit) begin
          run_d    = 1'b1;
          active_d = idx_q;
          count_d  = '0;
          state_d  = ST_DONE;
        end else if (idx_q == LastIdx) begin
          state_d = ST_DONE;
        end else begin
          idx_d = EntryIdxW'(idx_q + 1'b1);
        end
      end
      ST_PREP: begin
        den_d      = DenW'(entry.fade * TpmW);
        limit_d    = (limit_full > {1'b0, CountLimitMax}) ? CountLimitMax
                                                          : limit_full[15:0];
        disabled_d = !entry_on;
        state_d    = ST_CHECK;
      end
      ST_CHECK: begin
        led_d = 1'b1;
        if (disabled_q || (count_q > limit_q)) begin
          level_d = 8'd0;
          count_d = '0;
          run_d   = 1'b0;
          state_d = ST_DONE;
        end else if ((den_q == '0) || (count_q >= den_q)) begin
          level_d = LevelCap;
          count_d = 16'(count_q + 1'b1);
          state_d = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        // Here count < den, so the quotient is below 255 and fits a byte.
        if (div_sts.done) begin
          level_d = div_quot[7:0];
          count_d = 16'(count_q + 1'b1);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.led_write   = led_q;
          out_d.level       = level_q;
          out_d.running     = run_q;
          out_d.alarm_index = active_q;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= 1'b0;
      active_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      active_q    <= active_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  // Working registers and the result beat.
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    den_q      <= den_d;
    limit_q    <= limit_d;
    disabled_q <= disabled_d;
    led_q      <= led_d;
    level_q    <= level_d;
    out_q      <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The tick count only moves during a run.
  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_q |-> (count_q == '0))
    else $error("tick count nonzero while no run is active");

  // A result beat never carries a full-scale level.
  a_level_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.level <= LevelCap))
    else $error("level above cap");

  // A beat that does not drive the lamp carries level zero.
  a_quiet_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.led_write) |-> (out_data_o.level == 8'd0))
    else $error("nonzero level without lamp write");

  // The divider only works while the sequencer waits for it.
  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.busy |-> (state_q == ST_DIV))
    else $error("divider busy outside its wait state");

endmodule

>>> dv/tb_wakeup_alarm_light_ramp.sv
// Self-checking testbench for the sunrise alarm lamp ramp: directed and random
// time and tick beats, alarm table reprogramming over APB, scoreboard checks.
// Depends on wakr_pkg and the RTL top wakeup_alarm_light_ramp.
`timescale 1ns / 100ps

localparam int unsigned WeekdayMon  = 1;
localparam int unsigned WeekdayFri  = 5;
localparam int unsigned LevelFull   = 255;
localparam int unsigned ReportLimit = 10;

// Tracks the lamp state on its own and queues the result each beat should give.
class lamp_scoreboard;
  logic [31:0]         entry [wakr_pkg::EntrySlots];
  bit                  run_on;
  bit [2:0]            cur_alarm;
  bit [15:0]           ticks;
  wakr_pkg::wakr_out_t lamp_due [$];
  int unsigned         failures;
  int unsigned         beats_seen;

  function new();
    foreach (entry[i]) entry[i] = '0;
    entry[0]   = wakr_pkg::Entry0Reset;
    run_on     = 1'b0;
    cur_alarm  = '0;
    ticks      = '0;
    failures   = 0;
    beats_seen = 0;
  endfunction

  // Advances the lamp state by one accepted input beat.
  function void log_input_beat(wakr_pkg::wakr_in_t b);
    wakr_pkg::wakr_out_t  r;
    wakr_pkg::wakr_entry_t e;
    int unsigned          limit;
    int unsigned          span;
    int unsigned          lvl;
    r = '0;
    if (b.mode == wakr_pkg::ModeTime) begin
      // A start needs an idle lamp, no override and a weekday; first match wins.
      if (!b.override && !run_on && b.weekday >= WeekdayMon && b.weekday <= WeekdayFri) begin
        for (int i = 0; i < wakr_pkg::NumAlarmsDef && !run_on; i++) begin
          e = entry[i];
          if ((e.hour != '0 || e.minute != '0) && e.hour == {3'b000, b.hour} &&
              e.minute == {2'b00, b.minute}) begin
            run_on    = 1'b1;
            cur_alarm = 3'(i);
            ticks     = '0;
          end
        end
      end
    end else if (run_on) begin
      // Each tick reads the current register contents of the running entry.
      e     = entry[cur_alarm];
      limit = (32'(e.fade) + 32'(e.hold)) * wakr_pkg::TicksPerMinDef;
      if (limit > wakr_pkg::CountLimitMax) limit = wakr_pkg::CountLimitMax;
      r.led_write = 1'b1;
      if ((e.hour != '0 || e.minute != '0) && ticks <= limit) begin
        span = 32'(e.fade) * wakr_pkg::TicksPerMinDef;
        if (span == 0) lvl = wakr_pkg::LevelCap;
        else lvl = (LevelFull * ticks) / span;
        if (lvl > wakr_pkg::LevelCap) lvl = wakr_pkg::LevelCap;
        r.level = 8'(lvl);
        ticks   = ticks + 16'd1;
      end else begin
        ticks  = '0;
        run_on = 1'b0;
      end
    end
    r.running     = run_on;
    r.alarm_index = cur_alarm;
    lamp_due.push_back(r);
  endfunction

  // Compares one accepted result beat with the oldest expectation.
  function void check_lamp_beat(wakr_pkg::wakr_out_t got);
    wakr_pkg::wakr_out_t want;
    beats_seen++;
    if (lamp_due.size() == 0) begin
      failures++;
      if (failures <= ReportLimit)
        $display("lamp beat %0d arrived with none expected: led_write=%0b level=%0d",
                 beats_seen, got.led_write, got.level);
      return;
    end
    want = lamp_due.pop_front();
    if (got.led_write !== want.led_write || got.level !== want.level ||
        got.running !== want.running || got.alarm_index !== want.alarm_index) begin
      failures++;
      if (failures <= ReportLimit)
        $display("lamp beat %0d: expected led_write=%0b level=%0d running=%0b alarm=%0d",
                 beats_seen, want.led_write, want.level, want.running, want.alarm_index,
                 " / got led_write=%0b level=%0d running=%0b alarm=%0d",
                 got.led_write, got.level, got.running, got.alarm_index);
    end
  endfunction
endclass

module tb_wakeup_alarm_light_ramp;
  import wakr_pkg::*;

  localparam int unsigned IdlePct      = 12;
  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned RegStride    = 4;
  localparam int unsigned TailCycles   = 40;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned PhaseBeats   = 195;
  localparam int unsigned ExtremeBeats = 30;
  localparam int unsigned SteadyPhase  = 4;

  typedef enum int unsigned {PlanRandom, PlanAllOnes, PlanAllZero} plan_kind_e;

  logic            clk      = 1'b0;
  logic            rst_n    = 1'b0;
  logic            in_valid = 1'b0;
  wakr_in_t        in_data  = '0;
  logic            in_stall;
  logic            out_valid;
  logic            out_stall = 1'b0;
  wakr_out_t       out_data;
  logic            psel     = 1'b0;
  logic            penable  = 1'b0;
  logic            pwrite   = 1'b0;
  logic [ApbAw-1:0] paddr   = '0;
  logic [ApbDw-1:0] pwdata  = '0;
  logic [ApbDw-1:0] prdata;
  logic            pready;
  bit              steady   = 1'b0;
  logic [31:0]     plan [EntrySlots];
  lamp_scoreboard  sb = new;

  wakeup_alarm_light_ramp dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: check every accepted beat and stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_lamp_beat(out_data);
    out_stall <= !steady && ($urandom_range(0, 99) < IdlePct);
  end

  // Ends the run when neither channel has moved a beat for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic wakr_in_t beat_of(logic mode, int unsigned wd, int unsigned hr,
                                       int unsigned mn, logic ov);
    wakr_in_t b;
    b.mode     = mode;
    b.weekday  = 3'(wd);
    b.hour     = 5'(hr);
    b.minute   = 6'(mn);
    b.override = ov;
    return b;
  endfunction

  // Random alarm entry: mostly valid times and short ramps so runs finish often.
  function automatic logic [31:0] random_entry();
    wakr_entry_t e;
    int unsigned r;
    e.hour   = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 23))
                                            : 8'($urandom_range(0, 255));
    e.minute = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 59))
                                            : 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    e.fade = (r < 45) ? 8'd0 : (r < 90) ? 8'd1 : 8'($urandom_range(2, 3));
    e.hold = ($urandom_range(0, 99) < 75) ? 8'd0 : 8'd1;
    if ($urandom_range(0, 99) < 15) begin
      e.hour   = '0;
      e.minute = '0;
    end
    return e;
  endfunction

  // Next random beat: ticks during a run, start attempts on table times when idle.
  function automatic wakr_in_t next_beat();
    wakr_in_t    b;
    wakr_entry_t e;
    int unsigned r;
    b = wakr_in_t'(16'($urandom));
    r = $urandom_range(0, 99);
    if (sb.run_on) begin
      if (r < 90) b.mode = ModeTick;
    end else if (r < 55) begin
      e          = plan[$urandom_range(0, EntrySlots - 1)];
      b.mode     = ModeTime;
      b.hour     = e.hour[4:0];
      b.minute   = e.minute[5:0];
      b.weekday  = 3'($urandom_range(WeekdayMon, WeekdayFri));
      b.override = ($urandom_range(0, 99) < 8);
    end else if (r < 75) begin
      b.mode = ModeTick;
    end
    return b;
  endfunction

  // Offers one input beat, with an occasional gap first, until it is taken.
  task automatic send_beat(input wakr_in_t b);
    if (!steady && $urandom_range(0, 99) < IdlePct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.log_input_beat(b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.lamp_due.size() != 0) @(posedge clk);
  endtask

  // Writes the whole alarm table once the block has nothing in flight.
  task automatic load_plan();
    drain();
    for (int i = 0; i < EntrySlots; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ApbAw'(i * RegStride);
      pwdata  <= plan[i];
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      sb.entry[i] = plan[i];
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : stimulus
    plan_kind_e  kind;
    int unsigned beats;
    foreach (plan[i]) plan[i] = '0;
    plan[0] = Entry0Reset;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset table: weekend, bad weekday, override and disabled entries start nothing.
    send_beat(beat_of(ModeTick, 7, 31, 63, 1'b1));
    send_beat(beat_of(ModeTime, 0, 9, 0, 1'b0));
    send_beat(beat_of(ModeTime, 6, 9, 0, 1'b0));
    send_beat(beat_of(ModeTime, 7, 9, 0, 1'b0));
    send_beat(beat_of(ModeTime, 1, 9, 0, 1'b1));
    send_beat(beat_of(ModeTime, 2, 0, 0, 1'b0));
    send_beat(beat_of(ModeTime, 5, 9, 0, 1'b0));
    send_beat(beat_of(ModeTime, 1, 9, 0, 1'b0));
    send_beat(beat_of(ModeTick, 3, 9, 0, 1'b1));
    send_beat(beat_of(ModeTick, 0, 0, 0, 1'b0));
    send_beat(beat_of(ModeTick, 4, 12, 30, 1'b0));

    // Disable the running entry mid-run, zero fade, duplicate times, extreme entries.
    plan[0] = 32'h0000_0F19;
    plan[1] = 32'h173B_0000;
    plan[2] = 32'h1F3F_FFFF;
    plan[3] = 32'hFFFF_FFFF;
    plan[4] = 32'h0708_0102;
    plan[5] = 32'h071E_0000;
    plan[6] = 32'h071E_0100;
    plan[7] = 32'h0000_0000;
    load_plan();
    send_beat(beat_of(ModeTick, 1, 0, 0, 1'b0));
    send_beat(beat_of(ModeTick, 1, 0, 0, 1'b0));
    send_beat(beat_of(ModeTime, 3, 23, 59, 1'b0));
    send_beat(beat_of(ModeTick, 3, 23, 59, 1'b0));
    send_beat(beat_of(ModeTick, 3, 23, 59, 1'b0));
    send_beat(beat_of(ModeTime, 4, 7, 30, 1'b0));
    send_beat(beat_of(ModeTick, 4, 7, 30, 1'b0));
    send_beat(beat_of(ModeTick, 4, 7, 30, 1'b0));
    send_beat(beat_of(ModeTime, 2, 31, 63, 1'b0));
    send_beat(beat_of(ModeTick, 2, 31, 63, 1'b0));
    send_beat(beat_of(ModeTick, 2, 31, 63, 1'b0));
    send_beat(beat_of(ModeTick, 2, 31, 63, 1'b1));

    // Random phases, each on a freshly written table.
    for (int p = 0; p < NumPhases; p++) begin
      kind = (p == 2) ? PlanAllOnes : (p == 5) ? PlanAllZero : PlanRandom;
      foreach (plan[i]) begin
        case (kind)
          PlanAllOnes: plan[i] = '1;
          PlanAllZero: plan[i] = '0;
          default:     plan[i] = random_entry();
        endcase
      end
      load_plan();
      steady <= (p == SteadyPhase);
      beats = (kind == PlanRandom) ? PhaseBeats : ExtremeBeats;
      repeat (beats) send_beat(next_beat());
    end

    drain();
    repeat (TailCycles) @(posedge clk);
    if (sb.lamp_due.size() != 0) begin
      $display("%0d expected lamp beats never arrived", sb.lamp_due.size());
      sb.failures += sb.lamp_due.size();
    end
    if (sb.failures == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
rtl/wakr_pkg.sv
rtl/wakr_regs.sv
rtl/wakr_div.sv
rtl/wakeup_alarm_light_ramp.sv
dv/tb_wakeup_alarm_light_ramp.sv
